>>> rtl/core/tts_pkg.sv
// Shared types, constants and the sine ROM contents for the table/Taylor sine-cosine core.
// No dependencies; every design file in rtl/core but tts_stream_if imports this package.
package tts_pkg;

   // Fixed configuration. TABLE_SIZE must stay a power of two: the index wrap is a mask.
   localparam int TABLE_SIZE      = 64;
   localparam int ANGLE_FRAC_BITS = 24;
   localparam int OUT_FRAC_BITS   = 30;

   localparam int TAB_IDX_W = $clog2(TABLE_SIZE);
   localparam int IDX_W     = TAB_IDX_W + 30 - ANGLE_FRAC_BITS;
   localparam int IDX_SH    = ANGLE_FRAC_BITS + 20;
   localparam int ROUND_SH  = 62 - OUT_FRAC_BITS;
   localparam int ACC_W     = 65;

   localparam int REDUCE_STAGES  = 3;
   localparam int POLY_STAGES    = 4;
   localparam int COMBINE_STAGES = 3;
   localparam int STAGES         = REDUCE_STAGES + POLY_STAGES + COMBINE_STAGES;

   // 1/(2*pi) in Q64, split into halves for two 32x32 products
   localparam logic [31:0] INV_TWO_PI_HI = 32'h28BE_60DB;
   localparam logic [31:0] INV_TWO_PI_LO = 32'h9391_054A;
   localparam logic [63:0] TWO_PI_Q60    = 64'h6487_ED51_10B4_611A;
   localparam logic [63:0] HALF_PI_Q60   = 64'h1921_FB54_442D_1846;
   localparam logic [63:0] UNIT_Q60      = 64'd1 << 60;
   // table spacing 2*pi/TABLE_SIZE, rounded to Q32
   localparam logic [31:0] STEP_Q32 =
      32'(((TWO_PI_Q60 / TABLE_SIZE) + (64'd1 << 27)) >> 28);

   // exact reciprocal multipliers: x/3 for x < 2^33, x/15 for x < 2^32
   localparam logic [31:0] RECIP3     = 32'hAAAA_AAAB;
   localparam int          RECIP3_SH  = 33;
   localparam logic [31:0] RECIP15    = 32'h8888_8889;
   localparam int          RECIP15_SH = 35;

   localparam int SERIES_TERMS = 14;
   typedef logic [63:0] series_div_type [SERIES_TERMS];
   localparam series_div_type SIN_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812};
   localparam series_div_type COS_DIV = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
      64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756};

   typedef logic signed [31:0]      angle_type;
   typedef logic signed [31:0]      sample_type;
   typedef logic signed [ACC_W-1:0] acc_type;
   typedef sample_type              table_type [TABLE_SIZE];

   typedef struct packed {
      angle_type angle;
   } req_payload_type;

   typedef struct packed {
      sample_type sine_value;
      sample_type cosine_value;
   } rsp_payload_type;

   typedef struct packed {
      logic [STAGES-1:0] en;
      logic [STAGES-1:0] valid;
   } pipe_ctl_type;

   typedef struct packed {
      logic [31:0]          ad;
      logic                 dneg;
      logic [TAB_IDX_W-1:0] tab_idx;
   } reduce_out_type;

   typedef struct packed {
      acc_type            sp;
      acc_type            cp;
      logic signed [32:0] bq;
      sample_type         s;
      sample_type         c;
   } poly_out_type;

   // (a*b) >> 60 for a, b below 2^61
   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ah, al, bh, bl, mid;
      ah  = a >> 32;
      al  = a & 64'h0000_0000_FFFF_FFFF;
      bh  = b >> 32;
      bl  = b & 64'h0000_0000_FFFF_FFFF;
      mid = ah * bl + al * bh + ((al * bl) >> 32);
      return ((ah * bh) << 4) + (mid >> 28);
   endfunction

   // ROM image: sin(2*pi*k/TABLE_SIZE) in Q2.30, built from octant symmetry and a series
   function automatic table_type build_sine_table();
      table_type   tab;
      logic [63:0] quad, rem, u, phi, p2, ts, tc, ss, cc, tmp, pick;
      logic        flip;
      for (int k = 0; k < TABLE_SIZE; k++) begin
         quad = (64'(k) * 64'd4) / TABLE_SIZE;
         rem  = (64'(k) * 64'd4) % TABLE_SIZE;
         flip = (rem * 64'd2) > 64'(TABLE_SIZE);
         u    = flip ? (64'(TABLE_SIZE) - rem) : rem;
         phi  = (HALF_PI_Q60 / TABLE_SIZE) * u + ((HALF_PI_Q60 % TABLE_SIZE) * u) / TABLE_SIZE;
         p2   = mul_q60(phi, phi);
         ts   = phi;
         tc   = UNIT_Q60;
         ss   = phi;
         cc   = UNIT_Q60;
         for (int j = 0; j < SERIES_TERMS; j++) begin
            ts = mul_q60(ts, p2) / SIN_DIV[j];
            tc = mul_q60(tc, p2) / COS_DIV[j];
            if (j % 2 == 0) begin
               ss = ss - ts;
               cc = cc - tc;
            end else begin
               ss = ss + ts;
               cc = cc + tc;
            end
         end
         if (flip) begin
            tmp = ss;
            ss  = cc;
            cc  = tmp;
         end
         pick   = quad[0] ? cc : ss;
         pick   = (pick + (64'd1 << 29)) >> 30;
         tab[k] = (quad >= 64'd2) ? -sample_type'(pick[31:0]) : sample_type'(pick[31:0]);
      end
      return tab;
   endfunction

   localparam table_type SINE_TABLE = build_sine_table();

endpackage

>>> rtl/core/tts_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload type comes from tts_pkg at the point of instantiation.
interface tts_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/tts_pipe_ctrl.sv
// Valid bits and per-stage load enables for the sine-cosine pipeline.
// Depends on tts_pkg (STAGES, pipe_ctl_type).
module tts_pipe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 out_ready,
   output tts_pkg::pipe_ctl_type ctl
);
   import tts_pkg::*;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] en;

   // a stage loads when the output drains or any stage at or after it is empty
   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         en[k] = out_ready || ((valid_ff | STAGES'((1 << k) - 1)) != {STAGES{1'b1}});
      end
      valid_in[0] = en[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.en    = en;
   assign ctl.valid = valid_ff;

endmodule

>>> rtl/core/tts_reduce.sv
// Range reduction: angle to table index and Q32 residual, three register stages.
// Depends on tts_pkg.
module tts_reduce (
   input  logic                         clock,
   input  logic [tts_pkg::REDUCE_STAGES-1:0] stage_en,
   input  tts_pkg::angle_type           angle,
   output tts_pkg::reduce_out_type      result
);
   import tts_pkg::*;

   typedef struct packed {
      logic        neg;
      logic [31:0] mag;
      logic [63:0] hi;
      logic [63:0] lo;
   } s1_type;

   typedef struct packed {
      logic             neg;
      logic [31:0]      mag;
      logic [IDX_W-1:0] idx;
   } s2_type;

   s1_type         s1_ff, s1_in;
   s2_type         s2_ff, s2_in;
   reduce_out_type s3_ff, s3_in;

   logic [63:0]      turns;
   logic [63:0]      rounded;
   logic [63:0]      resid;
   logic [63:0]      resid_mag;
   logic [IDX_W-1:0] signed_idx;

   always_comb begin
      // stage 1: magnitude times 1/(2*pi), two partial products
      s1_in.neg = angle[31];
      s1_in.mag = angle[31] ? 32'(-angle) : 32'(angle);
      s1_in.hi  = 64'(s1_in.mag) * 64'(INV_TWO_PI_HI);
      s1_in.lo  = 64'(s1_in.mag) * 64'(INV_TWO_PI_LO);

      // stage 2: round turns*TABLE_SIZE to the nearest table point
      turns      = (s1_ff.hi + (s1_ff.lo >> 32)) >> 12;
      rounded    = (turns << TAB_IDX_W) + (64'd1 << (IDX_SH - 1));
      s2_in.idx  = IDX_W'(rounded >> IDX_SH);
      s2_in.neg  = s1_ff.neg;
      s2_in.mag  = s1_ff.mag;

      // stage 3: residual against the table point, folded index
      resid         = (64'(s2_ff.mag) << (32 - ANGLE_FRAC_BITS))
                      - 64'(STEP_Q32) * 64'(s2_ff.idx);
      resid_mag     = resid[63] ? -resid : resid;
      s3_in.ad      = resid_mag[31:0];
      s3_in.dneg    = s2_ff.neg ^ resid[63];
      signed_idx    = s2_ff.neg ? -s2_ff.idx : s2_ff.idx;
      s3_in.tab_idx = signed_idx[TAB_IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) s1_ff <= s1_in;
      if (stage_en[1]) s2_ff <= s2_in;
      if (stage_en[2]) s3_ff <= s3_in;
   end

   assign result = s3_ff;

endmodule

>>> rtl/core/tts_poly.sv
// ROM read and Taylor correction terms A and B, four register stages.
// Depends on tts_pkg (SINE_TABLE, reciprocal constants).
module tts_poly (
   input  logic                             clock,
   input  logic [tts_pkg::POLY_STAGES-1:0]  stage_en,
   input  tts_pkg::reduce_out_type          red,
   output tts_pkg::poly_out_type            result
);
   import tts_pkg::*;

   typedef struct packed {
      logic [31:0] ad;
      logic        dneg;
      logic [31:0] e2;
      sample_type  s;
      sample_type  c;
   } s4_type;

   typedef struct packed {
      logic [31:0] ad;
      logic        dneg;
      logic [31:0] e2h;
      logic [31:0] e2d6;
      logic [31:0] e4;
      sample_type  s;
      sample_type  c;
   } s5_type;

   typedef struct packed {
      logic [31:0] ad;
      logic        dneg;
      logic [32:0] pa;
      logic [32:0] pb;
      sample_type  s;
      sample_type  c;
   } s6_type;

   s4_type       s4_ff, s4_in;
   s5_type       s5_ff, s5_in;
   s6_type       s6_ff, s6_in;
   poly_out_type s7_ff, s7_in;

   logic [TAB_IDX_W-1:0] cos_idx;
   logic [63:0]          sq_prod;
   logic [63:0]          q4_prod;
   logic [63:0]          d6_prod;
   logic [63:0]          d24_prod;
   logic [63:0]          d120_prod;
   logic [31:0]          q24;
   logic [31:0]          q120;
   logic [33:0]          pa_sum;
   logic [33:0]          pb_sum;
   logic [64:0]          b_prod;
   logic [31:0]          bm;
   logic signed [32:0]   bm_ext;
   acc_type              s_ext;
   acc_type              c_ext;
   acc_type              pa_ext;

   always_comb begin
      // stage 4: table reads and d^2
      cos_idx  = red.tab_idx + TAB_IDX_W'(TABLE_SIZE / 4);
      sq_prod  = 64'(red.ad) * 64'(red.ad);
      s4_in.ad   = red.ad;
      s4_in.dneg = red.dneg;
      s4_in.e2   = sq_prod[63:32];
      s4_in.s    = SINE_TABLE[red.tab_idx];
      s4_in.c    = SINE_TABLE[cos_idx];

      // stage 5: d^4, d^2/2, d^2/6
      q4_prod    = 64'(s4_ff.e2) * 64'(s4_ff.e2);
      d6_prod    = 64'(s4_ff.e2 >> 1) * 64'(RECIP3);
      s5_in.ad   = s4_ff.ad;
      s5_in.dneg = s4_ff.dneg;
      s5_in.e4   = q4_prod[63:32];
      s5_in.e2h  = s4_ff.e2 >> 1;
      s5_in.e2d6 = 32'(d6_prod >> RECIP3_SH);
      s5_in.s    = s4_ff.s;
      s5_in.c    = s4_ff.c;

      // stage 6: d^4/24, d^4/120 and the two series sums
      d24_prod   = 64'(s5_ff.e4 >> 3) * 64'(RECIP3);
      d120_prod  = 64'(s5_ff.e4 >> 3) * 64'(RECIP15);
      q24        = 32'(d24_prod >> RECIP3_SH);
      q120       = 32'(d120_prod >> RECIP15_SH);
      pa_sum     = (34'd1 << 32) - 34'(s5_ff.e2h) + 34'(q24);
      pb_sum     = (34'd1 << 32) - 34'(s5_ff.e2d6) + 34'(q120);
      s6_in.ad   = s5_ff.ad;
      s6_in.dneg = s5_ff.dneg;
      s6_in.pa   = pa_sum[32:0];
      s6_in.pb   = pb_sum[32:0];
      s6_in.s    = s5_ff.s;
      s6_in.c    = s5_ff.c;

      // stage 7: B = d*P with sign, s*A and c*A
      b_prod   = 65'(s6_ff.ad) * 65'(s6_ff.pb);
      bm       = 32'(b_prod >> 32);
      bm_ext   = $signed({1'b0, bm});
      s_ext    = acc_type'(s6_ff.s);
      c_ext    = acc_type'(s6_ff.c);
      pa_ext   = acc_type'({1'b0, s6_ff.pa});
      s7_in.bq = s6_ff.dneg ? -bm_ext : bm_ext;
      s7_in.sp = s_ext * pa_ext;
      s7_in.cp = c_ext * pa_ext;
      s7_in.s  = s6_ff.s;
      s7_in.c  = s6_ff.c;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) s4_ff <= s4_in;
      if (stage_en[1]) s5_ff <= s5_in;
      if (stage_en[2]) s6_ff <= s6_in;
      if (stage_en[3]) s7_ff <= s7_in;
   end

   assign result = s7_ff;

endmodule

>>> rtl/core/tts_combine.sv
// Cross products, Q62 sums and rounding to the output format, three register stages.
// Depends on tts_pkg.
module tts_combine (
   input  logic                               clock,
   input  logic [tts_pkg::COMBINE_STAGES-1:0] stage_en,
   input  tts_pkg::poly_out_type              pol,
   output tts_pkg::rsp_payload_type           result
);
   import tts_pkg::*;

   localparam acc_type HALF = acc_type'(1) << (ROUND_SH - 1);

   typedef struct packed {
      acc_type sb;
      acc_type cb;
      acc_type sp;
      acc_type cp;
   } s8_type;

   typedef struct packed {
      acc_type sacc;
      acc_type cacc;
   } s9_type;

   s8_type          s8_ff, s8_in;
   s9_type          s9_ff, s9_in;
   rsp_payload_type s10_ff, s10_in;

   acc_type s_ext;
   acc_type c_ext;
   acc_type bq_ext;
   acc_type s_bias;
   acc_type c_bias;
   acc_type s_round;
   acc_type c_round;

   always_comb begin
      // stage 8: s*B and c*B
      s_ext    = acc_type'(pol.s);
      c_ext    = acc_type'(pol.c);
      bq_ext   = acc_type'(pol.bq);
      s8_in.sb = s_ext * bq_ext;
      s8_in.cb = c_ext * bq_ext;
      s8_in.sp = pol.sp;
      s8_in.cp = pol.cp;

      // stage 9: Q62 sums
      s9_in.sacc = s8_ff.sp + s8_ff.cb;
      s9_in.cacc = s8_ff.cp - s8_ff.sb;

      // stage 10: round half away from zero as one biased arithmetic shift
      s_bias  = s9_ff.sacc[ACC_W-1] ? HALF - acc_type'(1) : HALF;
      c_bias  = s9_ff.cacc[ACC_W-1] ? HALF - acc_type'(1) : HALF;
      s_round = (s9_ff.sacc + s_bias) >>> ROUND_SH;
      c_round = (s9_ff.cacc + c_bias) >>> ROUND_SH;
      s10_in.sine_value   = s_round[31:0];
      s10_in.cosine_value = c_round[31:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) s8_ff  <= s8_in;
      if (stage_en[1]) s9_ff  <= s9_in;
      if (stage_en[2]) s10_ff <= s10_in;
   end

   assign result = s10_ff;

endmodule

>>> rtl/core/table_taylor_sincos.sv
// Top level of the table-lookup sine/cosine core with Taylor correction.
// Depends on tts_pkg, tts_stream_if, tts_pipe_ctrl, tts_reduce, tts_poly, tts_combine.
//
//   channel   | dir | payload                             | format
//   ----------+-----+-------------------------------------+---------------------
//   req_if    | in  | angle                               | signed Q7.24 radians
//   rsp_if    | out | sine_value, cosine_value            | signed Q2.30
//
// An accepted req beat passes through the ten datapath register stages to its rsp beat;
// one beat is taken every cycle while rsp_if is ready or some stage is empty.
// Reset clears only the stage valid bits; the ROM is constant logic and needs none.
// On a rsp stall, empty stages keep filling (bubbles collapse) and req_if.ready
// drops only when all ten stages hold a beat.
module table_taylor_sincos (
   input  logic          clock,
   input  logic          reset,
   tts_stream_if.sink    req_if,
   tts_stream_if.source  rsp_if
);
   import tts_pkg::*;

   pipe_ctl_type    ctl;
   reduce_out_type  red;
   poly_out_type    pol;
   rsp_payload_type rsp_data;

   // valid bits and per-stage enables
   tts_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .out_ready (rsp_if.ready),
      .ctl       (ctl)
   );

   // stages 1-3: angle to table index and residual
   tts_reduce u_reduce (
      .clock    (clock),
      .stage_en (ctl.en[REDUCE_STAGES-1:0]),
      .angle    (req_if.payload.angle),
      .result   (red)
   );

   // stages 4-7: table read and correction polynomials
   tts_poly u_poly (
      .clock    (clock),
      .stage_en (ctl.en[REDUCE_STAGES+POLY_STAGES-1:REDUCE_STAGES]),
      .red      (red),
      .result   (pol)
   );

   // stages 8-10: combine and round; the last stage is the output register
   tts_combine u_combine (
      .clock    (clock),
      .stage_en (ctl.en[STAGES-1:REDUCE_STAGES+POLY_STAGES]),
      .pol      (pol),
      .result   (rsp_data)
   );

   assign req_if.ready   = ctl.en[0];
   assign rsp_if.valid   = ctl.valid[STAGES-1];
   assign rsp_if.payload = rsp_data;

`ifndef ASSERT_OFF
   // an accepted beat lands in the first stage
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> ctl.valid[0])
      else $error("accepted beat missing from first stage");

   // beats in flight change only by accepts and deliveries
   a_conserve: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         ($countones(ctl.valid) == $countones($past(ctl.valid))
            + int'($past(req_if.valid && req_if.ready))
            - int'($past(rsp_if.valid && rsp_if.ready))))
      else $error("beat lost or duplicated in pipeline");

   // any empty stage leaves room for a new beat
   a_room_ready: assert property (@(posedge clock) disable iff (reset)
      !(&ctl.valid) |-> req_if.ready)
      else $error("input stalled with a free stage");
`endif

endmodule

>>> tb/sincos_check_pkg.sv
// Result checking for the table/Taylor sine-cosine core: its own bit-exact predictor and
// the store of expected sine/cosine pairs. Depends on tts_pkg for the payload types only.
package sincos_check_pkg;
   import tts_pkg::angle_type;
   import tts_pkg::sample_type;
   import tts_pkg::rsp_payload_type;

   localparam int          TAB_SIZE    = 64;
   localparam int          ANGLE_FRAC  = 24;
   localparam int          ROUND_SHIFT = 62 - 30;
   localparam int          SERIES_LEN  = 14;
   localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1846;
   localparam logic [63:0] TWO_PI_Q60  = 64'h6487_ED51_10B4_611A;
   localparam logic [63:0] RECIP_HI    = 64'h0000_0000_28BE_60DB;
   localparam logic [63:0] RECIP_LO    = 64'h0000_0000_9391_054A;
   localparam logic [63:0] STEP_Q32    = ((TWO_PI_Q60 / TAB_SIZE) + (64'd1 << 27)) >> 28;
   localparam logic [63:0] ONE_Q32     = 64'd1 << 32;

   class sincos_scoreboard;
      sample_type      sine_rom [TAB_SIZE];
      rsp_payload_type pending_sincos [$];
      int unsigned     error_count;
      int unsigned     result_count;

      // fill the ROM image: octant symmetry plus a series at 60 fraction bits
      function new();
         logic [63:0] quad, rem, u, phi, p2, ts, tc, ss, cc, pick;
         logic        flip;
         error_count  = 0;
         result_count = 0;
         for (int k = 0; k < TAB_SIZE; k++) begin
            quad = (64'(k) * 4) / TAB_SIZE;
            rem  = (64'(k) * 4) % TAB_SIZE;
            flip = (rem * 2) > TAB_SIZE;
            u    = flip ? (TAB_SIZE - rem) : rem;
            phi  = (HALF_PI_Q60 / TAB_SIZE) * u + ((HALF_PI_Q60 % TAB_SIZE) * u) / TAB_SIZE;
            p2   = q60_product(phi, phi);
            ts   = phi;
            tc   = 64'd1 << 60;
            ss   = ts;
            cc   = tc;
            for (int j = 1; j <= SERIES_LEN; j++) begin
               ts = q60_product(ts, p2) / 64'((2 * j) * (2 * j + 1));
               tc = q60_product(tc, p2) / 64'((2 * j - 1) * (2 * j));
               if (j % 2 == 1) begin
                  ss = ss - ts;
                  cc = cc - tc;
               end else begin
                  ss = ss + ts;
                  cc = cc + tc;
               end
            end
            // past the octant the roles of sine and cosine swap
            if (flip)
               pick = quad[0] ? ss : cc;
            else
               pick = quad[0] ? cc : ss;
            pick = (pick + (64'd1 << 29)) >> 30;
            sine_rom[k] = (quad >= 2) ? -sample_type'(pick[31:0]) : sample_type'(pick[31:0]);
         end
      endfunction

      function logic [63:0] q60_product(logic [63:0] a, logic [63:0] b);
         logic [127:0] full;
         full = {64'd0, a} * {64'd0, b};
         return 64'(full >> 60);
      endfunction

      // drop 32 fraction bits, halves away from zero
      function sample_type round_q30(logic signed [65:0] v);
         logic [65:0] m;
         m = v[65] ? 66'(-v) : 66'(v);
         m = (m + (66'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
         return v[65] ? sample_type'(-m[31:0]) : sample_type'(m[31:0]);
      endfunction

      function rsp_payload_type predict_sincos(angle_type angle);
         logic                neg, dneg;
         logic [63:0]         mag, hi, lo, turns, idx, ad, e2, e4, pa, pb, bm;
         logic signed [63:0]  rm, bq;
         logic signed [65:0]  s_w, c_w, a_w, b_w;
         int                  i1, i2;
         rsp_payload_type     r;
         neg   = angle[31];
         mag   = neg ? (64'h1_0000_0000 - {32'd0, angle}) : {32'd0, angle};
         // turns = |x|/(2*pi) with 44 fraction bits, then round to a table point
         hi    = mag * RECIP_HI;
         lo    = mag * RECIP_LO;
         turns = (hi + (lo >> 32)) >> 12;
         idx   = (turns * TAB_SIZE + (64'd1 << (ANGLE_FRAC + 19))) >> (ANGLE_FRAC + 20);
         rm    = $signed(mag << (32 - ANGLE_FRAC)) - $signed(STEP_Q32 * idx);
         dneg  = neg ^ rm[63];
         ad    = rm[63] ? 64'(-rm) : 64'(rm);
         e2    = (ad * ad) >> 32;
         e4    = (e2 * e2) >> 32;
         pa    = ONE_Q32 - e2 / 2 + e4 / 24;
         pb    = ONE_Q32 - e2 / 6 + e4 / 120;
         bm    = (ad * pb) >> 32;
         bq    = dneg ? -$signed(bm) : $signed(bm);
         i1    = int'(idx % TAB_SIZE);
         if (neg && i1 != 0)
            i1 = TAB_SIZE - i1;
         i2    = (i1 + TAB_SIZE / 4) % TAB_SIZE;
         s_w   = sine_rom[i1];
         c_w   = sine_rom[i2];
         a_w   = $signed({2'b00, pa});
         b_w   = bq;
         r.sine_value   = round_q30(s_w * a_w + c_w * b_w);
         r.cosine_value = round_q30(c_w * a_w - s_w * b_w);
         return r;
      endfunction

      function void note_angle(angle_type angle);
         pending_sincos.push_back(predict_sincos(angle));
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
         error_count++;
      endtask

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         result_count++;
         if (pending_sincos.size() == 0) begin
            report_mismatch("unexpected result", {got.sine_value}, 32'd0);
         end else begin
            want = pending_sincos.pop_front();
            if (got.sine_value !== want.sine_value)
               report_mismatch("sine_value", got.sine_value, want.sine_value);
            if (got.cosine_value !== want.cosine_value)
               report_mismatch("cosine_value", got.cosine_value, want.cosine_value);
         end
      endtask
   endclass

endpackage

>>> tb/table_taylor_sincos_tb.sv
// Top level testbench of table_taylor_sincos: angle beats in, sine/cosine beats checked.
// Depends on tts_pkg, tts_stream_if, the core itself and sincos_check_pkg.
module table_taylor_sincos_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tts_pkg::*;
   import sincos_check_pkg::*;

   localparam int RESET_CYCLES   = 6;
   localparam int HOLD_CYCLES    = 120;   // long receiver hold-off, block fills and stalls
   localparam int HOLD_AFTER     = 500;   // results seen before the hold-off starts
   localparam int TAIL_CYCLES    = 30;    // wait well past the pipeline depth at the end
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PER_RUN = 577;
   localparam int SMALL_SPAN     = 421657428;  // about 8*pi in Q7.24
   localparam int N_CORNER       = 23;

   logic clock;
   logic reset;

   tts_stream_if #(.payload_type(req_payload_type)) req_ch ();
   tts_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   table_taylor_sincos DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   sincos_scoreboard sb = new();

   int          send_idle_pct;
   int          recv_idle_pct;
   bit          hold_done;
   int unsigned quiet_cycles;

   // Corner angles in Q7.24: zero, one LSB each way, both range ends, quarter turns,
   // one table step, points just either side of a midpoint between table points
   // (rounding of halves), their mirrors, and large magnitudes.
   angle_type corner_angles [N_CORNER] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
      32'sd26353589, 32'sd52707179, -32'sd52707179, 32'sd79060768,
      32'sd105414357, -32'sd105414357, 32'sd1647099,
      32'sd823549, 32'sd823550, -32'sd823549, -32'sd823550,
      32'sd2470648, 32'sd2470649, -32'sd2470649,
      32'sh6400_0000, 32'sh9C00_0000, 32'sh5555_5555, 32'shAAAA_AAAA
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watch both channels at the edge: note every accepted angle, check every result.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            sb.note_angle(req_ch.payload.angle);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.payload);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // End the run when nothing moves on either channel for too long.
   initial begin
      do @(posedge clock); while (quiet_cycles < WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver: stall at random, once hold off for a long stretch so the pipe fills.
   initial begin
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!hold_done && sb.result_count >= HOLD_AFTER) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            @(posedge clock);
         end
      end
   end

   // Offer one angle beat, idling first at the current rate; hold until accepted.
   task automatic send_angle(input angle_type angle);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= req_payload_type'(angle);
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drop valid and hold until every expected result has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending_sincos.size() != 0);
   endtask

   // Random angles: three in ten over the full range (every bit toggles), four in ten within
   // four turns either way, the rest right at table points and midpoints with a little jitter.
   task automatic run_random(input int count);
      int        pick;
      int        half_steps;
      angle_type angle;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            angle = angle_type'($urandom);
         end else if (pick < 7) begin
            angle = angle_type'(int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN);
         end else begin
            half_steps = int'($urandom_range(0, 5200)) - 2600;
            angle = angle_type'((longint'(half_steps) * 64'sd82354966) / 100
                                + int'($urandom_range(0, 16)) - 8);
         end
         send_angle(angle);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      send_idle_pct  = 31;
      recv_idle_pct  = 49;
      hold_done      = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners, then random with the sender mostly busy
      foreach (corner_angles[i])
         send_angle(corner_angles[i]);
      wait_drained();
      run_random(RANDOM_PER_RUN);
      wait_drained();

      // swap the idle rates
      send_idle_pct = 49;
      recv_idle_pct = 31;
      run_random(RANDOM_PER_RUN);
      wait_drained();

      // full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(RANDOM_PER_RUN);
      wait_drained();

      // let any stray beat surface before judging
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending_sincos.size() != 0)
         sb.report_mismatch("results left pending", sb.pending_sincos.size(), 32'd0);

      if (sb.error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
